[src/imufcp_pkg.sv]
// Shared types and constants of the inertial sensor frame parser.
package imufcp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FS_W    = 12;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned AXIS_W  = 28;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned OUT_DATA_W = 96;

  // Frame byte positions; the idle value means no frame is open.
  localparam logic [3:0] POS_HEADER       = 4'd0;
  localparam logic [3:0] POS_TYPE         = 4'd1;
  localparam logic [3:0] POS_PAYLOAD_LAST = 4'd7;
  localparam logic [3:0] POS_CHECKSUM     = 4'd10;
  localparam logic [3:0] POS_IDLE         = 4'd11;
  localparam logic [3:0] PAYLOAD_OFFSET   = 4'd2;
  localparam int unsigned PAYLOAD_BYTES   = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TYPE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TYPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FS   = 3'd6;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_FRAME  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] accel_type;
    logic [BYTE_W-1:0] rate_type;
    logic [BYTE_W-1:0] angle_type;
    logic [FS_W-1:0]   accel_fs;
    logic [FS_W-1:0]   rate_fs;
    logic [FS_W-1:0]   angle_fs;
  } cfg_t;

  // Decoded frame waiting for scaling; fs is zero on any error.
  typedef struct packed {
    status_t                  status;
    kind_t                    kind;
    logic [FS_W-1:0]          fs;
    logic signed [RAW_W-1:0]  raw_x;
    logic signed [RAW_W-1:0]  raw_y;
    logic signed [RAW_W-1:0]  raw_z;
    logic                     seen;
  } frm_t;

endpackage

[src/imufcp_parser.sv]
// Byte tracker: header, type and checksum checks, payload capture, decision register.
module imufcp_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  imufcp_pkg::cfg_t                 cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [imufcp_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                             frame_start,
  output logic                             frm_valid,
  input  logic                             frm_take,
  output imufcp_pkg::frm_t                 frm
);

  logic [3:0]                      pos, pos_next, pos_eff;
  logic [imufcp_pkg::BYTE_W-1:0]   running_sum, sum_next, sum_eff;
  logic                            header_ok;
  logic [imufcp_pkg::BYTE_W-1:0]   type_seen;
  logic [imufcp_pkg::BYTE_W-1:0]   payload [imufcp_pkg::PAYLOAD_BYTES];
  logic                            valid_latch;
  logic                            accept, in_frame, frame_done;
  logic [2:0]                      pay_idx;
  logic [3:0]                      pay_off;
  imufcp_pkg::frm_t                frm_next;
  logic                            known, ok;

  assign in_ready   = !frm_valid || frm_take;
  assign accept     = in_valid && in_ready;
  assign pos_eff    = frame_start ? imufcp_pkg::POS_HEADER : pos;
  assign sum_eff    = frame_start ? '0 : running_sum;
  assign in_frame   = pos_eff < imufcp_pkg::POS_IDLE;
  assign frame_done = accept && (pos_eff == imufcp_pkg::POS_CHECKSUM);
  assign pay_off    = pos_eff - imufcp_pkg::PAYLOAD_OFFSET;
  assign pay_idx    = pay_off[2:0];

  always_comb begin
    pos_next = pos;
    sum_next = running_sum;
    if (accept && in_frame) begin
      if (pos_eff == imufcp_pkg::POS_CHECKSUM) begin
        pos_next = imufcp_pkg::POS_IDLE;
        sum_next = sum_eff;
      end else begin
        pos_next = pos_eff + 4'd1;
        sum_next = sum_eff + rx_byte;
      end
    end else if (accept) begin
      pos_next = pos_eff;
      sum_next = sum_eff;
    end
  end

  // Decision taken when the checksum byte is transferred.
  always_comb begin
    known            = 1'b1;
    frm_next.status  = imufcp_pkg::ST_OK;
    frm_next.kind    = imufcp_pkg::KIND_ACCEL;
    frm_next.fs      = '0;
    frm_next.raw_x   = $signed({payload[1], payload[0]});
    frm_next.raw_y   = $signed({payload[3], payload[2]});
    frm_next.raw_z   = $signed({payload[5], payload[4]});
    if (type_seen == cfg.accel_type) begin
      frm_next.kind = imufcp_pkg::KIND_ACCEL;
      frm_next.fs   = cfg.accel_fs;
    end else if (type_seen == cfg.rate_type) begin
      frm_next.kind = imufcp_pkg::KIND_RATE;
      frm_next.fs   = cfg.rate_fs;
    end else if (type_seen == cfg.angle_type) begin
      frm_next.kind = imufcp_pkg::KIND_ANGLE;
      frm_next.fs   = cfg.angle_fs;
    end else begin
      known = 1'b0;
    end
    ok = 1'b0;
    if (!header_ok) begin
      frm_next.status = imufcp_pkg::ST_BAD_HEADER;
      frm_next.kind   = imufcp_pkg::KIND_ACCEL;
      frm_next.fs     = '0;
    end else if (!known || (running_sum != rx_byte)) begin
      frm_next.status = imufcp_pkg::ST_BAD_FRAME;
      frm_next.kind   = imufcp_pkg::KIND_ACCEL;
      frm_next.fs     = '0;
    end else begin
      ok = 1'b1;
    end
    frm_next.seen = valid_latch || ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= imufcp_pkg::POS_IDLE;
      running_sum <= '0;
      header_ok   <= 1'b0;
      type_seen   <= '0;
      valid_latch <= 1'b0;
      frm_valid   <= 1'b0;
    end else begin
      pos         <= pos_next;
      running_sum <= sum_next;
      if (accept && in_frame && (pos_eff == imufcp_pkg::POS_HEADER)) begin
        header_ok <= (rx_byte == cfg.header_byte);
      end
      if (accept && in_frame && (pos_eff == imufcp_pkg::POS_TYPE)) begin
        type_seen <= rx_byte;
      end
      if (frame_done) begin
        valid_latch <= frm_next.seen;
        frm_valid   <= 1'b1;
      end else if (frm_take) begin
        frm_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos_eff > imufcp_pkg::POS_TYPE) &&
        (pos_eff <= imufcp_pkg::POS_PAYLOAD_LAST)) begin
      payload[pay_idx] <= rx_byte;
    end
    if (frame_done) begin
      frm <= frm_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) frame_done |=> pos == imufcp_pkg::POS_IDLE)
    else $error("frame position did not return to idle after the checksum byte");
  assert property (@(posedge clk) disable iff (rst) pos <= imufcp_pkg::POS_IDLE)
    else $error("frame position out of range");
  assert property (@(posedge clk) disable iff (rst) valid_latch |=> valid_latch)
    else $error("valid-seen flag cleared without reset");
  assert property (@(posedge clk) disable iff (rst)
    frm_valid && (frm.status != imufcp_pkg::ST_OK) |-> (frm.fs == '0) &&
    (frm.kind == imufcp_pkg::KIND_ACCEL))
    else $error("errored frame carries a kind or a full scale");

endmodule

[src/imufcp_scale.sv]
// Axis scaling by the full-scale register and the result register.
module imufcp_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                frm_valid,
  output logic                                frm_take,
  input  imufcp_pkg::frm_t                    frm,
  output logic                                out_valid,
  input  logic                                out_ready,
  output imufcp_pkg::status_t                 status,
  output imufcp_pkg::kind_t                   kind,
  output logic signed [imufcp_pkg::AXIS_W-1:0] axis_x,
  output logic signed [imufcp_pkg::AXIS_W-1:0] axis_y,
  output logic signed [imufcp_pkg::AXIS_W-1:0] axis_z,
  output logic                                seen_valid
);

  localparam int unsigned PROD_W = imufcp_pkg::RAW_W + imufcp_pkg::FS_W + 1;

  logic                                   load;
  logic signed [imufcp_pkg::FS_W:0]       fs_s;
  logic signed [PROD_W-1:0]               prod_x, prod_y, prod_z;

  assign frm_take = !out_valid || out_ready;
  assign load     = frm_valid && frm_take;
  assign fs_s     = $signed({1'b0, frm.fs});
  assign prod_x   = frm.raw_x * fs_s;
  assign prod_y   = frm.raw_y * fs_s;
  assign prod_z   = frm.raw_z * fs_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status     <= frm.status;
      kind       <= frm.kind;
      axis_x     <= prod_x[imufcp_pkg::AXIS_W-1:0];
      axis_y     <= prod_y[imufcp_pkg::AXIS_W-1:0];
      axis_z     <= prod_z[imufcp_pkg::AXIS_W-1:0];
      seen_valid <= frm.seen;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != imufcp_pkg::ST_OK) |-> (axis_x == '0) && (axis_y == '0) &&
    (axis_z == '0))
    else $error("errored result carries nonzero axes");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == imufcp_pkg::ST_OK) |-> seen_valid)
    else $error("good result without the valid-seen flag");

endmodule

[src/imu_frame_checksum_parser_core.sv]
// Top level of the inertial sensor frame parser: configuration registers and stream ports.
//
// Input stream: one frame byte per transfer on s_axis_tdata, with s_axis_tuser high on
// the first byte of a frame. An 11-byte frame is header, type, three little-endian
// signed 16-bit axes, two spare bytes and an 8-bit sum of bytes 0 to 9.
// Output stream: one result per completed frame, holding status, kind, the three axes
// scaled by the kind's full-scale register (Q15) and a sticky valid-seen flag.
// Bytes after the checksum byte are dropped until the next first-byte flag.
// Throughput is one byte per cycle while s_axis_tready is high. A result reaches m_axis
// through the decision register, loaded on the transfer of its checksum byte, and then
// through the three 16x12 multipliers into the result register.
// When the receiver stalls, the result register and the decision register each hold
// one frame; once both are full, s_axis_tready drops, even in the middle of a frame,
// and stays low until the receiver takes the waiting result.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect on the next edge.
// Reset restores the default header, type codes and full scales, closes any open
// frame and clears the valid-seen flag.
module imu_frame_checksum_parser_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [7:0]                              s_axis_tdata,  // [7:0] rx_byte
  input  logic                                    s_axis_tuser,  // [0] frame_start
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // [1:0] status, [3:2] kind, [31:4] axis_x, [59:32] axis_y, [87:60] axis_z,
  // [88] seen_valid, [95:89] zero
  output logic [imufcp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  logic                                    cfg_we,
  input  logic [imufcp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [imufcp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned USED_W = 2 + 2 + 3 * imufcp_pkg::AXIS_W + 1;

  imufcp_pkg::cfg_t                          cfg;
  logic                                      frm_valid, frm_take;
  imufcp_pkg::frm_t                          frm;
  imufcp_pkg::status_t                       status;
  imufcp_pkg::kind_t                         kind;
  logic signed [imufcp_pkg::AXIS_W-1:0]      axis_x, axis_y, axis_z;
  logic                                      seen_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= 8'd85;
      cfg.accel_type  <= 8'd81;
      cfg.rate_type   <= 8'd82;
      cfg.angle_type  <= 8'd83;
      cfg.accel_fs    <= 12'd16;
      cfg.rate_fs     <= 12'd2000;
      cfg.angle_fs    <= 12'd180;
    end else if (cfg_we) begin
      case (cfg_index)
        imufcp_pkg::REG_HEADER:     cfg.header_byte <= cfg_data[7:0];
        imufcp_pkg::REG_ACCEL_TYPE: cfg.accel_type  <= cfg_data[7:0];
        imufcp_pkg::REG_RATE_TYPE:  cfg.rate_type   <= cfg_data[7:0];
        imufcp_pkg::REG_ANGLE_TYPE: cfg.angle_type  <= cfg_data[7:0];
        imufcp_pkg::REG_ACCEL_FS:   cfg.accel_fs    <= cfg_data;
        imufcp_pkg::REG_RATE_FS:    cfg.rate_fs     <= cfg_data;
        imufcp_pkg::REG_ANGLE_FS:   cfg.angle_fs    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  imufcp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .rx_byte     (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .frm_valid   (frm_valid),
    .frm_take    (frm_take),
    .frm         (frm)
  );

  imufcp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .frm_valid  (frm_valid),
    .frm_take   (frm_take),
    .frm        (frm),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .status     (status),
    .kind       (kind),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z),
    .seen_valid (seen_valid)
  );

  assign m_axis_tdata = {{(imufcp_pkg::OUT_DATA_W - USED_W){1'b0}}, seen_valid,
                         axis_z, axis_y, axis_x, kind, status};

endmodule

[tb/tb.sv]
// Self-checking testbench for the inertial sensor frame parser core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_BYTES  = 11;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic [imufcp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    imufcp_pkg::status_t             status;
    imufcp_pkg::kind_t               kind;
    logic [imufcp_pkg::AXIS_W-1:0]   ax;
    logic [imufcp_pkg::AXIS_W-1:0]   ay;
    logic [imufcp_pkg::AXIS_W-1:0]   az;
    logic                            seen;
  } decoded_t;

  class frame_checker;
    logic [imufcp_pkg::BYTE_W-1:0] hdr_code, accel_code, rate_code, angle_code;
    logic [imufcp_pkg::FS_W-1:0]   accel_fs, rate_fs, angle_fs;
    int unsigned       pos;
    logic [7:0]        sum;
    bit                hdr_ok;
    logic [7:0]        type_byte;
    logic [7:0]        payload [imufcp_pkg::PAYLOAD_BYTES];
    bit                seen;
    decoded_t          pending_results[$];
    int unsigned       mismatches, n_ok, n_bad_hdr, n_bad_frame;

    function new();
      hdr_code   = 8'd85;
      accel_code = 8'd81;
      rate_code  = 8'd82;
      angle_code = 8'd83;
      accel_fs   = 12'd16;
      rate_fs    = 12'd2000;
      angle_fs   = 12'd180;
      pos        = imufcp_pkg::POS_IDLE;
      sum        = '0;
      hdr_ok     = 0;
      type_byte  = '0;
      seen       = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void write_reg(logic [imufcp_pkg::CFG_IDX_W-1:0] idx,
                            logic [imufcp_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        imufcp_pkg::REG_HEADER:     hdr_code   = val[7:0];
        imufcp_pkg::REG_ACCEL_TYPE: accel_code = val[7:0];
        imufcp_pkg::REG_RATE_TYPE:  rate_code  = val[7:0];
        imufcp_pkg::REG_ANGLE_TYPE: angle_code = val[7:0];
        imufcp_pkg::REG_ACCEL_FS:   accel_fs   = val;
        imufcp_pkg::REG_RATE_FS:    rate_fs    = val;
        imufcp_pkg::REG_ANGLE_FS:   angle_fs   = val;
        default: ;
      endcase
    endfunction

    function logic [imufcp_pkg::AXIS_W-1:0] scaled(int unsigned axis,
                                                    logic [imufcp_pkg::FS_W-1:0] fs);
      int raw, prod;
      raw  = $signed({payload[2*axis+1], payload[2*axis]});
      prod = raw * int'(fs);
      return prod[imufcp_pkg::AXIS_W-1:0];
    endfunction

    function void note_byte(logic [7:0] b, bit start);
      decoded_t                      r;
      bit                            known;
      logic [imufcp_pkg::FS_W-1:0]   fs;
      imufcp_pkg::kind_t             k;
      if (start) begin
        pos = imufcp_pkg::POS_HEADER;
        sum = '0;
      end
      if (pos >= FRAME_BYTES) return;
      if (pos == imufcp_pkg::POS_HEADER) hdr_ok = (b == hdr_code);
      else if (pos == imufcp_pkg::POS_TYPE) type_byte = b;
      else if (pos <= imufcp_pkg::POS_PAYLOAD_LAST) payload[pos - imufcp_pkg::PAYLOAD_OFFSET] = b;
      if (pos < imufcp_pkg::POS_CHECKSUM) begin
        sum += b;
        pos++;
        return;
      end
      pos   = imufcp_pkg::POS_IDLE;
      known = 1;
      fs    = '0;
      k     = imufcp_pkg::KIND_ACCEL;
      // Earlier entries win when type codes coincide.
      if (type_byte == accel_code) begin
        k = imufcp_pkg::KIND_ACCEL; fs = accel_fs;
      end else if (type_byte == rate_code) begin
        k = imufcp_pkg::KIND_RATE; fs = rate_fs;
      end else if (type_byte == angle_code) begin
        k = imufcp_pkg::KIND_ANGLE; fs = angle_fs;
      end else begin
        known = 0;
      end
      r = '0;
      if (!hdr_ok) begin
        r.status = imufcp_pkg::ST_BAD_HEADER;
        n_bad_hdr++;
      end else if (!known || sum != b) begin
        r.status = imufcp_pkg::ST_BAD_FRAME;
        n_bad_frame++;
      end else begin
        r.status = imufcp_pkg::ST_OK;
        r.kind   = k;
        r.ax     = scaled(0, fs);
        r.ay     = scaled(1, fs);
        r.az     = scaled(2, fs);
        seen     = 1;
        n_ok++;
      end
      r.seen = seen;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [imufcp_pkg::OUT_DATA_W-1:0] d);
      decoded_t r;
      if (pending_results.size() == 0) begin
        $error("result 0x%0h arrived with no frame outstanding", d);
        mismatches++;
        return;
      end
      r = pending_results.pop_front();
      compare("status", 32'(r.status), 32'(d[1:0]));
      compare("kind", 32'(r.kind), 32'(d[3:2]));
      compare("axis_x", 32'(r.ax), 32'(d[31:4]));
      compare("axis_y", 32'(r.ay), 32'(d[59:32]));
      compare("axis_z", 32'(r.az), 32'(d[87:60]));
      compare("seen_valid", 32'(r.seen), 32'(d[88]));
      compare("padding", 0, 32'(d[95:89]));
    endfunction
  endclass

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  s_axis_tvalid = 1'b0;
  logic                                  s_axis_tready;
  logic [7:0]                            s_axis_tdata = '0;
  logic                                  s_axis_tuser = 1'b0;
  logic                                  m_axis_tvalid;
  logic                                  m_axis_tready = 1'b0;
  logic [imufcp_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
  logic                                  cfg_we = 1'b0;
  logic [imufcp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [imufcp_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  frame_checker sb;
  int unsigned  burst_left = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  ignored_bytes = 0;
  int unsigned  quiet_cycles = 0;
  logic [15:0]  stall_pat = 16'hFFFF;
  int unsigned  pat_age = 0;

  imu_frame_checksum_parser_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: ready follows a rotating pattern that is swapped out whenever pat_age wraps.
  always @(posedge clk) begin : rx_side
    logic [15:0] fresh;
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (pat_age == 47) begin
      case ($urandom_range(0, 3))
        0:       fresh = 16'hFFFF;
        1:       fresh = 16'($urandom);
        2:       fresh = 16'h00FF;
        default: fresh = 16'($urandom | $urandom);
      endcase
      if (fresh == 0) fresh = 16'h0001;
      stall_pat <= fresh;
      pat_age   <= 0;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
      pat_age   <= pat_age + 1;
    end
    m_axis_tready <= stall_pat[0];
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_reg(logic [imufcp_pkg::CFG_IDX_W-1:0] idx,
                         logic [imufcp_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_setting(logic [7:0] h, logic [7:0] a, logic [7:0] r, logic [7:0] g,
                               logic [11:0] fa, logic [11:0] fr, logic [11:0] fg);
    set_reg(imufcp_pkg::REG_HEADER, {4'h0, h});
    set_reg(imufcp_pkg::REG_ACCEL_TYPE, {4'h0, a});
    set_reg(imufcp_pkg::REG_RATE_TYPE, {4'h0, r});
    set_reg(imufcp_pkg::REG_ANGLE_TYPE, {4'h0, g});
    set_reg(imufcp_pkg::REG_ACCEL_FS, fa);
    set_reg(imufcp_pkg::REG_RATE_FS, fr);
    set_reg(imufcp_pkg::REG_ANGLE_FS, fg);
  endtask

  task automatic push_byte(logic [7:0] b, bit start);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk); while (!s_axis_tready);
    if (!start && sb.pos >= FRAME_BYTES) ignored_bytes++;
    sb.note_byte(b, start);
    bytes_sent++;
  endtask

  // Sends the first cut bytes of a frame; the checksum is XORed with sum_flip.
  task automatic send_frame(logic [7:0] hdr, logic [7:0] typ, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, logic [7:0] s8, logic [7:0] s9,
                            logic [7:0] sum_flip, int unsigned cut);
    logic [7:0] f [FRAME_BYTES];
    logic [7:0] acc;
    f = '{hdr, typ, x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8], s8, s9, 8'h00};
    acc = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) acc += f[i];
    f[FRAME_BYTES-1] = acc ^ sum_flip;
    for (int i = 0; i < cut; i++) push_byte(f[i], i == 0);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame(int unsigned cut);
    logic [7:0] h, t, flip;
    h = ($urandom_range(0, 19) == 0) ? 8'($urandom) : sb.hdr_code;
    case ($urandom_range(0, 9))
      0, 1, 2: t = sb.accel_code;
      3, 4, 5: t = sb.rate_code;
      6, 7, 8: t = sb.angle_code;
      default: t = 8'($urandom);
    endcase
    flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_frame(h, t, pick_axis(), pick_axis(), pick_axis(), 8'($urandom), 8'($urandom),
               flip, cut);
  endtask

  task automatic run_mix(int unsigned n_items);
    int unsigned goal;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      case ($urandom_range(0, 19))
        14, 15: random_frame($urandom_range(1, FRAME_BYTES - 1));
        16, 17: repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
        18, 19: repeat ($urandom_range(1, 15)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
        default: random_frame(FRAME_BYTES);
      endcase
    end
    // Close the phase on a whole frame so that no frame is open across a register change.
    random_frame(FRAME_BYTES);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          // Good acceleration frame at the axis extremes, stray bytes, a cut frame,
          // then a frame with both a bad header and an unknown type.
          send_frame(8'h55, 8'h51, 16'h8000, 16'h7FFF, 16'hFFFF, 8'h00, 8'hFF, 8'h00,
                     FRAME_BYTES);
          repeat (3) push_byte(8'hFF, 1'b0);
          send_frame(8'h55, 8'h52, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 3);
          send_frame(8'h00, 8'h00, 16'h0001, 16'h0002, 16'h0003, 8'h00, 8'h00, 8'h00,
                     FRAME_BYTES);
        end
        1: begin
          apply_setting(8'h00, 8'hFF, 8'h00, 8'h80, 12'hFFF, 12'hFFF, 12'hFFF);
          set_reg(REG_UNUSED, 12'hFFF);
        end
        // Acceleration and rate share a code.
        2: apply_setting(8'hFF, 8'h10, 8'h10, 8'h20, 12'd1, 12'd1, 12'd1);
        // Rate and angle share a code; acceleration scale of zero.
        3: apply_setting(8'hAA, 8'h01, 8'h7E, 8'h7E, 12'd0, 12'd2048, 12'd4095);
        default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                               ($urandom_range(0, 3) == 0) ? 12'd0 :
                                                             12'($urandom_range(1, 4095)));
      endcase
      run_mix(PHASE_ITEMS);
    end

    $display("Checked %0d frame results: %0d decoded, %0d bad header, %0d bad type or sum.",
             sb.n_ok + sb.n_bad_hdr + sb.n_bad_frame, sb.n_ok, sb.n_bad_hdr, sb.n_bad_frame);
    $display("Sent %0d bytes under %0d register settings, %0d of them outside any frame.",
             bytes_sent, NUM_PHASES, ignored_bytes);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
